[design/fiv_pkg.sv]
// ----------------------------------------------------------------------------
// fiv_pkg
// Shared types, register indexes and the nibble-wise CRC-32 helper for the
// firmware image verifier.
// ----------------------------------------------------------------------------
`default_nettype none

package fiv_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [DATA_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_MAGIC   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_MAGIC     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_CUR_SIZE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_ORIG_SIZE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_CRC       = 3'd4;

    // Request operation codes.
    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    typedef enum logic [1:0] {
        VERDICT_VALID        = 2'd0,
        VERDICT_BAD_MAGIC    = 2'd1,
        VERDICT_SIZE_EXCEEDS = 2'd2,
        VERDICT_CRC_MISMATCH = 2'd3
    } verdict_t;

    typedef struct packed {
        logic [DATA_W-1:0] expected_magic;
        logic [DATA_W-1:0] header_magic;
        logic [DATA_W-1:0] header_cur_size;
        logic [DATA_W-1:0] header_orig_size;
        logic [DATA_W-1:0] header_crc;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        verdict_t          verdict;
        logic [DATA_W-1:0] crc;
    } result_t;

    // Reflected CRC-32 (0xEDB88320) remainders for one 4-bit step.
    localparam logic [DATA_W-1:0] NIB_TABLE [16] = '{
        32'h0000_0000, 32'h1DB7_1064, 32'h3B6E_20C8, 32'h26D9_30AC,
        32'h76DC_4190, 32'h6B6B_51F4, 32'h4DB2_6158, 32'h5005_713C,
        32'hEDB8_8320, 32'hF00F_9344, 32'hD6D6_A3E8, 32'hCB61_B38C,
        32'h9B64_C2B0, 32'h86D3_D2D4, 32'hA00A_E278, 32'hBDBD_F21C
    };

    // Low nibble first, then high nibble.
    function automatic logic [DATA_W-1:0] crc_byte(input logic [DATA_W-1:0] c,
                                                   input logic [BYTE_W-1:0] b);
        logic [DATA_W-1:0] c_mid;
        c_mid    = (c >> 4) ^ NIB_TABLE[c[3:0] ^ b[3:0]];
        crc_byte = (c_mid >> 4) ^ NIB_TABLE[c_mid[3:0] ^ b[7:4]];
    endfunction

endpackage

`default_nettype wire

[design/fiv_if.sv]
// ----------------------------------------------------------------------------
// fiv_if
// Valid/ready channels of the firmware image verifier: request and result.
// ----------------------------------------------------------------------------
`default_nettype none

interface fiv_req_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface fiv_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  verdict;
    logic [31:0] computed_crc;

    modport source (output valid, output verdict, output computed_crc, input ready);
    modport sink   (input valid, input verdict, input computed_crc, output ready);
endinterface

`default_nettype wire

[design/fiv_crc_engine.sv]
// ----------------------------------------------------------------------------
// fiv_crc_engine
// Run state of one image check: header test on start, byte-wise CRC update,
// byte countdown and the final verdict, all within the accepting cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fiv_crc_engine
    import fiv_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic              operation,
    input  wire logic [BYTE_W-1:0] data_byte,
    input  wire cfg_t              cfg,
    output result_t                result
);

    logic [DATA_W-1:0] crc_reg;
    logic [DATA_W-1:0] crc_next;
    logic [DATA_W-1:0] bytes_left_reg;
    logic [DATA_W-1:0] bytes_left_next;
    logic              busy_reg;
    logic              busy_next;
    logic [DATA_W-1:0] crc_upd;
    logic [DATA_W-1:0] crc_fin;
    logic [DATA_W-1:0] left_dec;

    assign crc_upd  = crc_byte(crc_reg, data_byte);
    assign crc_fin  = ~crc_upd;
    assign left_dec = bytes_left_reg - DATA_W'(1);

    always_comb
    begin
        crc_next        = crc_reg;
        bytes_left_next = bytes_left_reg;
        busy_next       = busy_reg;
        result.valid    = 1'b0;
        result.verdict  = VERDICT_VALID;
        result.crc      = '0;
        if (accept)
        begin
            if (operation == OP_START)
            begin
                // A start drops any run in progress.
                crc_next        = CRC_INIT;
                bytes_left_next = '0;
                busy_next       = 1'b0;
                priority if (cfg.header_magic != cfg.expected_magic)
                begin
                    result.valid   = 1'b1;
                    result.verdict = VERDICT_BAD_MAGIC;
                end
                else if (cfg.header_cur_size > cfg.header_orig_size)
                begin
                    result.valid   = 1'b1;
                    result.verdict = VERDICT_SIZE_EXCEEDS;
                end
                else if (cfg.header_orig_size == '0)
                begin
                    result.valid   = 1'b1;
                    result.verdict = (cfg.header_crc == '0) ? VERDICT_VALID
                                                            : VERDICT_CRC_MISMATCH;
                end
                else
                begin
                    bytes_left_next = cfg.header_orig_size;
                    busy_next       = 1'b1;
                end
            end
            else if (busy_reg)
            begin
                bytes_left_next = left_dec;
                if (left_dec == '0)
                begin
                    crc_next       = CRC_INIT;
                    busy_next      = 1'b0;
                    result.valid   = 1'b1;
                    result.verdict = (crc_fin == cfg.header_crc) ? VERDICT_VALID
                                                                 : VERDICT_CRC_MISMATCH;
                    result.crc     = crc_fin;
                end
                else
                begin
                    crc_next = crc_upd;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg        <= CRC_INIT;
            bytes_left_reg <= '0;
            busy_reg       <= 1'b0;
        end
        else
        begin
            crc_reg        <= crc_next;
            bytes_left_reg <= bytes_left_next;
            busy_reg       <= busy_next;
        end
    end

endmodule

`default_nettype wire

[design/firmware_image_verifier.sv]
// ----------------------------------------------------------------------------
// firmware_image_verifier
// CRC-32 check of a firmware image against header words held in registers.
// ----------------------------------------------------------------------------
// Usage: software writes expected_magic, header_magic, header_cur_size,
// header_orig_size and header_crc through the write port (indexes 0 to 4)
// while the block is idle. A start request checks the header; a bad magic
// or a current size above the original size yields a result at once, as
// does an image of zero length. Then header_orig_size data requests feed
// the CRC, and the last one yields valid or CRC mismatch together with the
// computed CRC. Data requests while idle are dropped without a result.
// In the CRC engine the two nibble-table steps of a byte sit between the
// request handshake and the result register, so one request can be
// accepted in every clock cycle while the result channel does not stall,
// and a result appears in the cycle after the request that caused it.
// A single result register feeds the result channel; while it holds a
// result that the receiver does not take, req.ready is low.
// Reset clears the configuration, the run state and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module firmware_image_verifier
    import fiv_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    fiv_req_if.sink                   req,
    fiv_res_if.source                 res,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0]    cfg_wdata
);

    cfg_t              cfg_reg;
    logic              accept;
    result_t           result;
    logic              out_valid_reg;
    verdict_t          out_verdict_reg;
    logic [DATA_W-1:0] out_crc_reg;

    assign req.ready = !out_valid_reg || res.ready;
    assign accept    = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_EXPECTED_MAGIC:   cfg_reg.expected_magic   <= cfg_wdata;
                REG_HEADER_MAGIC:     cfg_reg.header_magic     <= cfg_wdata;
                REG_HEADER_CUR_SIZE:  cfg_reg.header_cur_size  <= cfg_wdata;
                REG_HEADER_ORIG_SIZE: cfg_reg.header_orig_size <= cfg_wdata;
                REG_HEADER_CRC:       cfg_reg.header_crc       <= cfg_wdata;
                default:              ;
            endcase
        end
    end

    fiv_crc_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .operation (req.operation),
        .data_byte (req.data_byte),
        .cfg       (cfg_reg),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            out_valid_reg <= result.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_verdict_reg <= VERDICT_VALID;
            out_crc_reg     <= '0;
        end
        else if (result.valid)
        begin
            out_verdict_reg <= result.verdict;
            out_crc_reg     <= result.crc;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.verdict      = out_verdict_reg;
    assign res.computed_crc = out_crc_reg;

endmodule

`default_nettype wire

[design/fiv_checker.sv]
// ----------------------------------------------------------------------------
// fiv_checker
// Port-level checks of the firmware image verifier, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fiv_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic        res_valid,
    input wire logic        res_ready,
    input wire logic [1:0]  verdict,
    input wire logic [31:0] computed_crc
);

    // A stalled result must hold still.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(verdict) && $stable(computed_crc))
        else $error("stalled result changed");

    // Header failures report a zero CRC.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (verdict == 2'd1 || verdict == 2'd2) |-> computed_crc == 32'd0)
        else $error("header failure with nonzero CRC");

    // A new result only follows an accepted request.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(req_valid && req_ready))
        else $error("result without a request");

    // With the result register empty the block takes requests.
    assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> req_ready)
        else $error("request stalled with empty result register");

endmodule

bind firmware_image_verifier fiv_checker u_fiv_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .verdict      (res.verdict),
    .computed_crc (res.computed_crc)
);

`default_nettype wire
